@@ sv/mandelbrot_escape_time_defines.svh @@
// Assertion macros for the checker file.
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define MET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MET_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/met_pkg.sv @@
// Types and constants for the escape-time evaluator.
package met_pkg;

    localparam int WORD_W     = 32;
    localparam int CNT_W      = 12;
    localparam int PIX_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

    // register map
    localparam cfg_idx_t REG_ORIGIN_RE = 3'd0;
    localparam cfg_idx_t REG_ORIGIN_IM = 3'd1;
    localparam cfg_idx_t REG_STEP_RE   = 3'd2;
    localparam cfg_idx_t REG_STEP_IM   = 3'd3;
    localparam cfg_idx_t REG_MAX_ITER  = 3'd4;

    // reset values, Q4.28
    localparam word_t ORIGIN_RE_RST = -32'sd369828896;
    localparam word_t ORIGIN_IM_RST = 32'sd12839697;
    localparam word_t STEP_RE_RST   = 32'sd29360;
    localparam word_t STEP_IM_RST   = 32'sd46976;
    localparam cnt_t  MAX_ITER_RST  = 12'd768;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

endpackage

@@ sv/mandelbrot_escape_time.sv @@
// Escape-time evaluator: maps a pixel to c and iterates z = z*z + c.
//
// Usage
//   Command channel: pulse start with pixel_x/pixel_y while busy is low; the beat is
//   taken at that edge and busy rises on the next cycle.
//   Result channel: done is high for exactly one cycle with iteration_count and
//   escaped. The receiver cannot stall; it must take the beat in that cycle.
//   Config port: cfg_we/cfg_index/cfg_data write one register per edge, no
//   handshake. Index 0..4 = origin_re, origin_im, step_re, step_im,
//   max_iterations; other indexes are dropped. Write only while busy is low.
// Schedule
//   One signed 32x32 multiplier with a registered product does all the math.
//   Mapping runs through MAP_X, MAP_Y and MAP_END (two products, two saturating
//   adds); each iteration runs through SQ_R, SQ_I, CROSS and UPDATE (r*r, i*i,
//   r*i, then the update). done rises after the UPDATE that reaches the limit
//   (768 at reset), or after the CROSS check in which the point escapes. One
//   pixel is worked on at a time: busy falls in the cycle done is high, so a new
//   start can be taken right then.
// Reset
//   rst_n is asynchronous, active low: sequencer to idle, done low, config
//   registers back to their reset values. No clearing pass is needed.
module mandelbrot_escape_time
    import met_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int COORD_BITS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  pix_t      pixel_x,
    input  pix_t      pixel_y,
    output logic      done,
    output cnt_t      iteration_count,
    output logic      escaped,
    input  logic      cfg_we,
    input  cfg_idx_t  cfg_index,
    input  cfg_data_t cfg_data
);

    // widths derived from the parameters and the word sizes
    localparam int CW     = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
    localparam int PROD_W = 2 * WORD_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;         // floored product
    localparam int MP_W   = CW + WORD_W + 1;             // pixel * step
    localparam int SW_A   = SH_W + 2;
    localparam int SW_B   = FRAC_BITS + 4;
    localparam int SW_C   = MP_W + 1;
    localparam int SW_AB  = (SW_A > SW_B) ? SW_A : SW_B;
    localparam int SUM_W  = (SW_AB > SW_C) ? SW_AB : SW_C;

    localparam logic signed [SUM_W-1:0] FOUR =
        {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS + 2);

    // sequencer
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MAP_X   = 3'd1;
    localparam logic [2:0] S_MAP_Y   = 3'd2;
    localparam logic [2:0] S_MAP_END = 3'd3;
    localparam logic [2:0] S_SQ_R    = 3'd4;
    localparam logic [2:0] S_SQ_I    = 3'd5;
    localparam logic [2:0] S_CROSS   = 3'd6;
    localparam logic [2:0] S_UPDATE  = 3'd7;

    function automatic word_t sat_word(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-WORD_W:0] hi;
        hi = v[SUM_W-1:WORD_W-1];
        if ((&hi) || !(|hi))
            return v[WORD_W-1:0];
        else if (v[SUM_W-1])
            return WORD_MIN;
        else
            return WORD_MAX;
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_sh(input logic signed [SH_W-1:0] v);
        return {{(SUM_W-SH_W){v[SH_W-1]}}, v};
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_word(input word_t v);
        return {{(SUM_W-WORD_W){v[WORD_W-1]}}, v};
    endfunction

    // config registers
    word_t origin_re_reg, origin_im_reg, step_re_reg, step_im_reg;
    cnt_t  max_iter_reg;

    // datapath / control registers
    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           px_reg, px_next, py_reg, py_next;
    word_t                   cre_reg, cre_next, cim_reg, cim_next;
    word_t                   r_reg, r_next, i_reg, i_next;
    logic signed [SH_W-1:0]  r2_reg, r2_next, i2_reg, i2_next;
    cnt_t                    iter_reg, iter_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                    done_reg, done_next;
    cnt_t                    count_reg, count_next;
    logic                    esc_reg, esc_next;

    // shared multiplier operands
    word_t mul_a, mul_b;

    logic signed [SH_W-1:0]  prod_sh;
    logic signed [SUM_W-1:0] map_prod;
    logic signed [SUM_W-1:0] mag_sum, r_sum, i_sum;
    cnt_t                    iter_inc;

    always_comb
    begin
        case (state_reg)
            S_MAP_X:
            begin
                mul_a = step_re_reg;
                mul_b = word_t'({{(WORD_W-CW){1'b0}}, px_reg});
            end
            S_MAP_Y:
            begin
                mul_a = step_im_reg;
                mul_b = word_t'({{(WORD_W-CW){1'b0}}, py_reg});
            end
            S_SQ_R:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
            S_SQ_I:
            begin
                mul_a = i_reg;
                mul_b = i_reg;
            end
            default:
            begin
                mul_a = r_reg;
                mul_b = i_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // arithmetic shift of the product is the floor
    assign prod_sh  = prod_reg[PROD_W-1:FRAC_BITS];
    assign map_prod = {{(SUM_W-MP_W){prod_reg[MP_W-1]}}, prod_reg[MP_W-1:0]};
    assign mag_sum  = ext_sh(r2_reg) + ext_sh(prod_sh);
    assign r_sum    = ext_sh(r2_reg) - ext_sh(i2_reg) + ext_word(cre_reg);
    assign i_sum    = ext_sh(prod_sh) + ext_sh(prod_sh) + ext_word(cim_reg);
    assign iter_inc = iter_reg + cnt_t'(1);

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cre_next   = cre_reg;
        cim_next   = cim_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        r2_next    = r2_reg;
        i2_next    = i2_reg;
        iter_next  = iter_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        esc_next   = esc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next    = pixel_x[CW-1:0];
                    py_next    = pixel_y[CW-1:0];
                    iter_next  = '0;
                    state_next = S_MAP_X;
                end
            end
            S_MAP_X:
                state_next = S_MAP_Y;
            S_MAP_Y:
            begin
                cre_next   = sat_word(ext_word(origin_re_reg) + map_prod);
                state_next = S_MAP_END;
            end
            S_MAP_END:
            begin
                cim_next = sat_word(ext_word(origin_im_reg) + map_prod);
                r_next   = cre_reg;
                i_next   = cim_next;
                if (max_iter_reg == '0)
                begin
                    // zero limit: no iteration at all
                    done_next  = 1'b1;
                    count_next = '0;
                    esc_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_SQ_R;
            end
            S_SQ_R:
                state_next = S_SQ_I;
            S_SQ_I:
            begin
                r2_next    = prod_sh;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                i2_next = prod_sh;
                if (mag_sum >= FOUR)
                begin
                    done_next  = 1'b1;
                    count_next = iter_reg;
                    esc_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                r_next    = sat_word(r_sum);
                i_next    = sat_word(i_sum);
                iter_next = iter_inc;
                if (iter_inc == max_iter_reg)
                begin
                    done_next  = 1'b1;
                    count_next = iter_inc;
                    esc_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_SQ_R;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
            esc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            esc_reg   <= esc_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        cre_reg  <= cre_next;
        cim_reg  <= cim_next;
        r_reg    <= r_next;
        i_reg    <= i_next;
        r2_reg   <= r2_next;
        i2_reg   <= i2_next;
        iter_reg <= iter_next;
        prod_reg <= prod_next;
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg <= ORIGIN_RE_RST;
            origin_im_reg <= ORIGIN_IM_RST;
            step_re_reg   <= STEP_RE_RST;
            step_im_reg   <= STEP_IM_RST;
            max_iter_reg  <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_RE: origin_re_reg <= word_t'(cfg_data);
                REG_ORIGIN_IM: origin_im_reg <= word_t'(cfg_data);
                REG_STEP_RE:   step_re_reg   <= word_t'(cfg_data);
                REG_STEP_IM:   step_im_reg   <= word_t'(cfg_data);
                REG_MAX_ITER:  max_iter_reg  <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign iteration_count = count_reg;
    assign escaped         = esc_reg;

endmodule

@@ sv/met_checker.sv @@
// Port-level checks for the escape-time evaluator, bound to the top level.
`include "mandelbrot_escape_time_defines.svh"

module met_checker
    import met_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // work only begins on an accepted command
    `MET_ASSERT(a_busy_needs_start, $rose(busy) |-> $past(start), "busy rose without start")

    // work ends exactly with a result beat
    `MET_ASSERT(a_end_with_result, $fell(busy) |-> done, "busy fell without a result")

    // a result is a single-cycle strobe
    `MET_ASSERT(a_done_pulse, done |=> !done, "done held for more than one cycle")

    // reset parks the sequencer
    `MET_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (!busy && !done), "not idle in reset")

endmodule

bind mandelbrot_escape_time met_checker u_met_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the escape-time evaluator.
`timescale 1ns / 1ps

module tb_top;
    import met_pkg::*;

    // Block parameters, kept at their defaults
    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;

    // |z|^2 bound in the same fixed-point format as the block
    localparam longint ESCAPE_RADIUS_SQ = longint'(4) << FRAC_BITS;

    // About 770 beats in all; the directed part sends 18 of them
    localparam int RANDOM_ITEMS = 752;

    // Only a few frames run long limits, of up to 4095 iterations per beat
    localparam int MAX_SLOW_FRAMES = 4;

    // The watchdog bound leaves wide margin over the slowest legal run
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_REPORTS = 10;

    // Idle time after the last drain, before the owed results are counted
    localparam int TAIL_CYCLES = 16;

    // One expected result beat, plus the pixel that caused it for the report
    typedef struct {
        cnt_t count;
        logic escaped_flag;
        pix_t px;
        pix_t py;
    } escape_result_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    pix_t      pixel_x;
    pix_t      pixel_y;
    logic      done;
    cnt_t      iteration_count;
    logic      escaped;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    // Shadow of the register file, updated on every write we issue
    word_t origin_re_cur;
    word_t origin_im_cur;
    word_t step_re_cur;
    word_t step_im_cur;
    cnt_t  limit_cur;

    // Results still owed by the block, oldest first
    escape_result_t pending_results[$];
    escape_result_t want;

    int fail_count;
    int cycle_count;

    mandelbrot_escape_time #(
        .FRAC_BITS (FRAC_BITS),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .done           (done),
        .iteration_count(iteration_count),
        .escaped        (escaped),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Watchdog: a hung block or a lost beat ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    //--------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------

    // Clamp to the signed 32-bit word range
    function automatic longint clamp_word(longint v);
        if (v > longint'(WORD_MAX))
            return longint'(WORD_MAX);
        if (v < longint'(WORD_MIN))
            return longint'(WORD_MIN);
        return v;
    endfunction

    // Track a register write; indexes past the map are dropped by the block too
    function automatic void store_reg(cfg_idx_t idx, cfg_data_t d);
        case (idx)
            REG_ORIGIN_RE: origin_re_cur = word_t'(d);
            REG_ORIGIN_IM: origin_im_cur = word_t'(d);
            REG_STEP_RE:   step_re_cur   = word_t'(d);
            REG_STEP_IM:   step_im_cur   = word_t'(d);
            REG_MAX_ITER:  limit_cur     = d[CNT_W-1:0];
            default:       ;
        endcase
    endfunction

    // Map the pixel to c, then iterate z = z*z + c from z = c.
    // Products are 64-bit and floored by an arithmetic shift.
    function automatic escape_result_t escape_time(pix_t x, pix_t y);
        escape_result_t res;
        longint c_re;
        longint c_im;
        longint zr;
        longint zi;
        longint zr2;
        longint zi2;
        longint zri;
        int unsigned n;
        // mapping saturates to the word range
        c_re = clamp_word(longint'(origin_re_cur) + longint'(x) * longint'(step_re_cur));
        c_im = clamp_word(longint'(origin_im_cur) + longint'(y) * longint'(step_im_cur));
        zr = c_re;
        zi = c_im;
        n = 0;
        res.escaped_flag = 1'b0;
        // a zero limit runs no iteration at all
        while (n < limit_cur)
        begin
            zr2 = (zr * zr) >>> FRAC_BITS;
            zi2 = (zi * zi) >>> FRAC_BITS;
            if (zr2 + zi2 >= ESCAPE_RADIUS_SQ)
            begin
                res.escaped_flag = 1'b1;
                break;
            end
            // imaginary update uses the old real part
            zri = (zr * zi) >>> FRAC_BITS;
            zi = clamp_word(zri + zri + c_im);
            zr = clamp_word(zr2 - zi2 + c_re);
            n++;
        end
        res.count = cnt_t'(n);
        res.px = x;
        res.py = y;
        return res;
    endfunction

    //--------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, taken at the edge ending it
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result beat: count %0d escaped %0b",
                             iteration_count, escaped);
            end
            else
            begin
                want = pending_results.pop_front();
                if (iteration_count !== want.count || escaped !== want.escaped_flag)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("pixel (%0d,%0d): count exp %0d got %0d, escaped exp %0b got %0b",
                                 want.px, want.py, want.count, iteration_count,
                                 want.escaped_flag, escaped);
                end
            end
        end
    end

    //--------------------------------------------------------------------
    // Drivers
    //--------------------------------------------------------------------

    // Offer one pixel and hold it until the block takes it. start is left high so
    // a following beat can go out back to back; callers drop it to idle.
    task automatic send_pixel(pix_t x, pix_t y);
        start   <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(escape_time(x, y));
    endtask

    // Lower start and wait for every owed result; the block is then idle
    task automatic drain();
        start <= 1'b0;
        while (busy || pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One register write per edge; cfg_we is left high for the caller to drop
    task automatic write_reg(cfg_idx_t idx, cfg_data_t d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        store_reg(idx, d);
    endtask

    // Full register set; only call while idle. The limit write carries junk in
    // the bits above the 12-bit field.
    task automatic set_config(word_t ore, word_t oim, word_t sre, word_t sim, cnt_t lim);
        cfg_data_t lim_word;
        lim_word = $urandom();
        lim_word[CNT_W-1:0] = lim;
        write_reg(REG_ORIGIN_RE, ore);
        write_reg(REG_ORIGIN_IM, oim);
        write_reg(REG_STEP_RE, sre);
        write_reg(REG_STEP_IM, sim);
        write_reg(REG_MAX_ITER, lim_word);
        cfg_we <= 1'b0;
    endtask

    //--------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------

    // Reset view: corners and a middle point at the power-on limit of 768
    task automatic test_reset_view();
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel('0, '1);
        send_pixel('1, '0);
        send_pixel(pix_t'(2048), pix_t'(1365));
        drain();
    endtask

    // c = 0 never escapes, so the count sits at the limit: 1, 0, 4095.
    // Then a point far outside escapes before the first iteration, at limit 768.
    task automatic test_iteration_limits();
        set_config('0, '0, '0, '0, cnt_t'(1));
        send_pixel('0, '0);
        drain();
        set_config('0, '0, '0, '0, '0);
        send_pixel('1, '1);
        send_pixel(pix_t'($urandom()), pix_t'($urandom()));
        drain();
        set_config('0, '0, '0, '0, '1);
        send_pixel(pix_t'(123), pix_t'(456));
        drain();
        set_config(WORD_MAX, WORD_MAX, '0, '0, MAX_ITER_RST);
        send_pixel('0, '0);
        drain();
    endtask

    // Origin and step at the word extremes push the mapped c into saturation
    task automatic test_mapping_saturation();
        set_config(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, cnt_t'(16));
        send_pixel('1, '1);
        send_pixel('0, '0);
        drain();
        set_config(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, cnt_t'(16));
        send_pixel('1, '1);
        send_pixel(pix_t'(1), pix_t'(1));
        send_pixel('1, '0);
        drain();
    endtask

    // Writes past the register map must leave the configuration alone
    task automatic test_unused_index();
        set_config(-32'sd536870912, -32'sd322122547, 32'sd196608, 32'sd160000, cnt_t'(40));
        for (int k = int'(REG_MAX_ITER) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(cfg_idx_t'(k), $urandom());
        cfg_we <= 1'b0;
        send_pixel(pix_t'(1024), pix_t'(2048));
        send_pixel(pix_t'($urandom()), pix_t'($urandom()));
        send_pixel(pix_t'($urandom()), pix_t'($urandom()));
        drain();
    endtask

    // Random frames: each picks a view, then streams pixels in bursts with
    // random gaps. Most views frame the set so counts spread over the range;
    // some are wild words (mostly instant escape or saturation), some use a
    // zero limit, and a few run long limits.
    task automatic test_random_frames();
        int sent;
        int frame_left;
        int burst;
        int mode;
        int slow_frames;
        word_t ore;
        word_t oim;
        word_t sre;
        word_t sim;
        cnt_t lim;
        sent = 0;
        slow_frames = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0 && slow_frames >= MAX_SLOW_FRAMES)
                mode = 9;
            // region around the set: re in [-2.5, 1.0], im in [-1.5, 1.5]
            ore = int'($urandom_range(0, 939524096)) - 671088640;
            oim = int'($urandom_range(0, 805306368)) - 402653184;
            sre = int'($urandom_range(0, 400000)) - 200000;
            sim = int'($urandom_range(0, 400000)) - 200000;
            lim = cnt_t'($urandom_range(1, 64));
            frame_left = $urandom_range(15, 35);
            case (mode)
                0:
                begin
                    lim = cnt_t'($urandom_range(256, 4095));
                    frame_left = 3;
                    slow_frames++;
                end
                1:
                begin
                    ore = $urandom();
                    oim = $urandom();
                    sre = $urandom();
                    sim = $urandom();
                end
                2:
                    lim = '0;
                default: ;
            endcase
            set_config(ore, oim, sre, sim, lim);
            while (frame_left > 0 && sent < RANDOM_ITEMS)
            begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst && frame_left > 0 && sent < RANDOM_ITEMS; b++)
                begin
                    send_pixel(pix_t'($urandom()), pix_t'($urandom()));
                    sent++;
                    frame_left--;
                end
                // a quarter of bursts run straight into the next one
                if ($urandom_range(0, 3) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 60))
                        @(posedge clk);
                end
            end
            drain();
        end
    endtask

    //--------------------------------------------------------------------
    // Sequence
    //--------------------------------------------------------------------
    initial
    begin
        fail_count  = 0;
        cycle_count = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        pixel_x   <= '0;
        pixel_y   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        origin_re_cur = ORIGIN_RE_RST;
        origin_im_cur = ORIGIN_IM_RST;
        step_re_cur   = STEP_RE_RST;
        step_im_cur   = STEP_IM_RST;
        limit_cur     = MAX_ITER_RST;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_view();
        test_iteration_limits();
        test_mapping_saturation();
        test_unused_index();
        test_random_frames();

        drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            fail_count++;
            $display("%0d results never arrived", pending_results.size());
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/met_pkg.sv
sv/mandelbrot_escape_time.sv
sv/met_checker.sv
tb/tb_top.sv
